// File: src/upc_pkg.sv
// shared types, character constants and lookup functions for the percent codec
`default_nettype none

package upc_pkg;

	// data and configuration widths
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned USER_W     = 2;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// default depth of the job queue between front and back
	localparam int unsigned JOB_DEPTH  = 4;

	// register indexes, selected by paddr[2]
	localparam logic REG_DIRECTION  = 1'b0;
	localparam logic REG_SPACE_PLUS = 1'b1;

	// direction codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// characters with a special role
	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic [BYTE_W-1:0] data;   // byte to emit, or byte to escape
		logic              triple; // emit percent and two hex digits
		logic              last;   // closes the message
		logic              err;    // error result
	} job_t;

	// characters that pass through unchanged
	function automatic logic is_pass(input logic [BYTE_W-1:0] c);
		logic res;
		res = 1'b0;
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
		    (c >= 8'h30 && c <= 8'h39)) begin
			res = 1'b1;
		end else begin
			case (c)
				8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40,
				8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
				8'h2B, 8'h2C, 8'h3B, 8'h3D,
				8'h22, 8'h2D, 8'h5F, 8'h2E, 8'h7E: res = 1'b1;
				default: res = 1'b0;
			endcase
		end
		return res;
	endfunction

	// uppercase hex digit value, bit 4 set for anything else
	function automatic logic [4:0] hex_val(input logic [BYTE_W-1:0] c);
		logic [4:0] res;
		res = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			res = {1'b0, 4'(c - CH_ZERO)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			res = {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
		end
		return res;
	endfunction

	// nibble to uppercase hex character
	function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
		logic [BYTE_W-1:0] res;
		if (v < 4'd10) begin
			res = CH_ZERO + {4'b0, v};
		end else begin
			res = CH_UPPER_A + {4'b0, v} - 8'd10;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: src/upc_front.sv
// front end: accepts input bytes, tracks escape state and queues output jobs
`default_nettype none

module upc_front
	import upc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              direction,
	input  wire logic              space_plus,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              msg_last,
	output logic                   job_valid,
	input  wire logic              job_ready,
	output job_t                   job
);

	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	logic [1:0] phase_q;
	logic [3:0] nib_q;
	logic       err_q;

	logic [1:0] phase_d;
	logic [3:0] nib_d;
	logic       err_d;
	logic       want;
	logic       pass;
	logic [4:0] hv;
	logic       accept;

	assign pass     = is_pass(in_byte);
	assign hv       = hex_val(in_byte);
	assign in_ready = job_ready;
	assign accept   = in_valid & in_ready;
	assign job_valid = in_valid & want;

	// classify the byte and work out the next escape state
	always_comb begin
		phase_d    = phase_q;
		nib_d      = nib_q;
		err_d      = err_q;
		want       = 1'b0;
		job.data   = in_byte;
		job.triple = 1'b0;
		job.last   = msg_last;
		job.err    = 1'b0;
		if (direction == DIR_ENCODE) begin
			want = 1'b1;
			if (pass) begin
				job.data = in_byte;
			end else if (space_plus && in_byte == CH_SPACE) begin
				job.data = CH_PLUS;
			end else begin
				job.triple = 1'b1;
			end
		end else if (err_q) begin
			want = 1'b0;
		end else begin
			case (phase_q)
				PH_HIGH: begin
					if (hv[4] || msg_last) begin
						job.err = 1'b1;
					end else begin
						nib_d   = hv[3:0];
						phase_d = PH_LOW;
					end
				end
				PH_LOW: begin
					if (hv[4]) begin
						job.err = 1'b1;
					end else begin
						want     = 1'b1;
						job.data = {nib_q, hv[3:0]};
						phase_d  = PH_NONE;
						nib_d    = 4'd0;
					end
				end
				default: begin
					phase_d = PH_NONE;
					if (in_byte == CH_PERCENT) begin
						if (msg_last) begin
							job.err = 1'b1;
						end else begin
							phase_d = PH_HIGH;
						end
					end else if (space_plus && in_byte == CH_PLUS) begin
						want     = 1'b1;
						job.data = CH_SPACE;
					end else if (pass) begin
						want = 1'b1;
					end else begin
						job.err = 1'b1;
					end
				end
			endcase
			// an error result aborts the rest of the message
			if (job.err) begin
				want     = 1'b1;
				job.data = '0;
				job.last = 1'b1;
				phase_d  = PH_NONE;
				nib_d    = 4'd0;
				err_d    = ~msg_last;
			end
		end
		// message end clears everything
		if (msg_last) begin
			phase_d = PH_NONE;
			nib_d   = 4'd0;
			err_d   = 1'b0;
		end
	end

	// escape state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
			nib_q   <= 4'd0;
			err_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			nib_q   <= nib_d;
			err_q   <= err_d;
		end
	end

endmodule

`default_nettype wire

// File: src/upc_fifo.sv
// small job queue between the front and back ends
`default_nettype none

module upc_fifo
	import upc_pkg::*;
#(
	parameter int unsigned DEPTH = JOB_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  job_t      push_job,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output job_t      pop_job
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid & push_ready;
	assign pop        = pop_ready & pop_valid;
	assign pop_job    = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/upc_back.sv
// back end: expands queued jobs into output bytes behind an output register
`default_nettype none

module upc_back
	import upc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	output logic                   job_ready,
	input  job_t                   job,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_data,
	output logic                   out_last,
	output logic [USER_W-1:0]      out_user
);

	logic [1:0]        beat_q;
	logic              valid_q;
	logic [BYTE_W-1:0] data_q;
	logic              last_q;
	logic [USER_W-1:0] user_q;

	logic              load;
	logic              final_beat;
	logic [BYTE_W-1:0] beat_data;
	logic              beat_run_last;
	logic              beat_msg_end;

	assign load       = job_valid & (~valid_q | out_ready);
	assign final_beat = ~job.triple | (beat_q == 2'd2);
	assign job_ready  = load & final_beat;

	// select the byte for the current beat of the job
	always_comb begin
		beat_run_last = final_beat;
		beat_msg_end  = final_beat & job.last;
		if (!job.triple) begin
			beat_data = job.data;
		end else begin
			case (beat_q)
				2'd0:    beat_data = CH_PERCENT;
				2'd1:    beat_data = hex_char(job.data[7:4]);
				default: beat_data = hex_char(job.data[3:0]);
			endcase
		end
	end

	// beat counter within an escape
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q  <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q <= final_beat ? 2'd0 : beat_q + 2'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= beat_data;
			last_q <= beat_msg_end;
			user_q <= {job.err, beat_run_last};
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;
	assign out_user  = user_q;

endmodule

`default_nettype wire

// File: src/url_percent_codec.sv
// top level of the streaming percent encoder and decoder
//
// Input stream: s_tdata carries one source byte, s_tlast marks the last byte
// of a message. Output stream: m_tdata carries one produced byte, m_tlast
// closes the message, m_tuser[0] marks the last result of an input byte and
// m_tuser[1] flags a decode error (data zero, message aborted).
// The APB port holds direction (address 0) and space_plus (address 4); write
// them only while no transfer is in flight.
// The input byte is written into the job queue, and the back end loads its
// result into the output register. The output carries one transfer per cycle
// while m_tready is high and jobs are queued. A byte that encodes to an escape
// gives three output bytes, any other byte one or none. The front end takes a
// byte per cycle while the job queue has room, so it runs ahead of a slow
// output. When m_tready is low the output register holds, the back end stops,
// and once the job queue fills s_tready drops. Reset clears the escape state,
// the queue and the output valid flag, and sets both registers to encode mode
// without the plus option.
`default_nettype none

module url_percent_codec
	import upc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = JOB_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// apb configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,  // [7:0] in_byte
	input  wire logic                  s_tlast,
	// output stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [BYTE_W-1:0]     m_tdata,  // [7:0] out_byte
	output logic                       m_tlast,
	output logic      [USER_W-1:0]     m_tuser   // [0] run_last, [1] error
);

	logic dir_q;
	logic sp_q;
	logic wr_en;

	logic front_valid;
	logic front_ready;
	job_t front_job;
	logic back_valid;
	logic back_ready;
	job_t back_job;

	// configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
			sp_q  <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_DIRECTION:  dir_q <= pwdata[0];
				default:        sp_q  <= pwdata[0];
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[2])
			REG_SPACE_PLUS: prdata = {{(APB_DATA_W-1){1'b0}}, sp_q};
			default:        prdata = {{(APB_DATA_W-1){1'b0}}, dir_q};
		endcase
	end

	upc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.direction  (dir_q),
		.space_plus (sp_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.msg_last   (s_tlast),
		.job_valid  (front_valid),
		.job_ready  (front_ready),
		.job        (front_job)
	);

	upc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_job    (back_job)
	);

	upc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.job       (back_job),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_user  (m_tuser)
	);

endmodule

`default_nettype wire

// File: src/upc_checker.sv
// port-level checks for the percent codec, bound to the top level
`default_nettype none

module upc_checker
	import upc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              pready,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [BYTE_W-1:0] m_tdata,
	input wire logic              m_tlast,
	input wire logic [USER_W-1:0] m_tuser
);

	// an error result is a lone, message-closing zero byte
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0] && m_tdata == '0)
		else $error("error result not closing with zero data");

	// message end only on the last result of an input byte
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("message end inside a multi-byte result");

	// a stalled output transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output changed while stalled");

	// the configuration port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind url_percent_codec upc_checker u_upc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the streaming percent encoder and decoder
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import upc_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 1000;
	localparam int PHASE_ITEMS   = 22;

	// register plan for the random phases, bit p belongs to phase p
	localparam logic [5:0] DIR_PLAN  = 6'b110011;
	localparam logic [5:0] PLUS_PLAN = 6'b011001;

	// one produced byte with its flags
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       msg_end;
		logic       err;
	} result_t;

	// one source byte waiting to be sent
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} stim_t;

	// characters passed through in both directions (decode may map plus to space)
	function automatic logic char_passes(input logic [7:0] c);
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
			return 1'b1;
		end
		case (c)
			":", "/", "?", "#", "[", "]", "@", "!", "$", "&", "'", "(", ")", "*",
			"+", ",", ";", "=", "\"", "-", "_", ".", "~": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// value of an uppercase hex digit, bit 4 set for any other byte
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return {1'b0, 4'(c - 8'h30)};
		end
		if (c >= "A" && c <= "F") begin
			return {1'b0, 4'(c - 8'h37)};
		end
		return 5'h10;
	endfunction

	// nibble to uppercase hex character ('A' minus ten is 0x37)
	function automatic logic [7:0] nibble_char(input logic [3:0] v);
		return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
	endfunction

	// codec predictor and result checker
	class codec_scoreboard;
		result_t     pending_q[$];
		logic        dir_mode;
		logic        plus_opt;
		logic [1:0]  esc_phase;
		logic [3:0]  hi_nibble;
		logic        dropping;
		int unsigned mismatches;
		int unsigned bytes_in;
		int unsigned results_out;
		int unsigned error_results;

		function new();
			dir_mode      = DIR_ENCODE;
			plus_opt      = 1'b0;
			mismatches    = 0;
			bytes_in      = 0;
			results_out   = 0;
			error_results = 0;
			clear_msg();
		endfunction

		function void clear_msg();
			esc_phase = 2'd0;
			hi_nibble = 4'd0;
			dropping  = 1'b0;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function void set_register(input logic idx, input logic val);
			if (idx == REG_DIRECTION) begin
				dir_mode = val;
			end else begin
				plus_opt = val;
			end
		endfunction

		function void push_result(input logic [7:0] d, input logic rl, input logic me,
				input logic er);
			result_t r;
			r.data     = d;
			r.run_last = rl;
			r.msg_end  = me;
			r.err      = er;
			pending_q.push_back(r);
		endfunction

		// malformed decode input: one error result, drop up to message end
		function void abort_msg(input logic last);
			push_result(8'h00, 1'b1, 1'b1, 1'b1);
			esc_phase = 2'd0;
			hi_nibble = 4'd0;
			dropping  = !last;
		endfunction

		// work out the results of one accepted source byte
		function void note_byte(input logic [7:0] b, input logic last);
			logic [4:0] v;
			bytes_in++;
			if (dir_mode == DIR_ENCODE) begin
				if (char_passes(b)) begin
					push_result(b, 1'b1, last, 1'b0);
				end else if (plus_opt && b == CH_SPACE) begin
					push_result(CH_PLUS, 1'b1, last, 1'b0);
				end else begin
					push_result(CH_PERCENT, 1'b0, 1'b0, 1'b0);
					push_result(nibble_char(b[7:4]), 1'b0, 1'b0, 1'b0);
					push_result(nibble_char(b[3:0]), 1'b1, last, 1'b0);
				end
				if (last) clear_msg();
				return;
			end
			if (dropping) begin
				if (last) clear_msg();
				return;
			end
			v = digit_value(b);
			if (esc_phase == 2'd1) begin
				// high digit; a message end here truncates the escape
				if (v[4] || last) begin
					abort_msg(last);
				end else begin
					hi_nibble = v[3:0];
					esc_phase = 2'd2;
				end
				return;
			end
			if (esc_phase == 2'd2) begin
				if (v[4]) begin
					abort_msg(last);
				end else begin
					push_result({hi_nibble, v[3:0]}, 1'b1, last, 1'b0);
					esc_phase = 2'd0;
					hi_nibble = 4'd0;
					if (last) clear_msg();
				end
				return;
			end
			esc_phase = 2'd0;
			if (b == CH_PERCENT) begin
				if (last) abort_msg(last);
				else esc_phase = 2'd1;
				return;
			end
			if (plus_opt && b == CH_PLUS) begin
				push_result(CH_SPACE, 1'b1, last, 1'b0);
			end else if (char_passes(b)) begin
				push_result(b, 1'b1, last, 1'b0);
			end else begin
				abort_msg(last);
				return;
			end
			if (last) clear_msg();
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(input logic [7:0] data, input logic mend,
				input logic [1:0] user);
			result_t want;
			results_out++;
			if (user[1]) error_results++;
			if (pending_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result data=%h tlast=%b tuser=%b",
					$time, data, mend, user);
				return;
			end
			want = pending_q.pop_front();
			if (data !== want.data) begin
				mismatches++;
				$display("%0t: out_byte expected %h actual %h", $time, want.data, data);
			end
			if (user[0] !== want.run_last) begin
				mismatches++;
				$display("%0t: run_last expected %b actual %b", $time, want.run_last, user[0]);
			end
			if (mend !== want.msg_end) begin
				mismatches++;
				$display("%0t: msg_end expected %b actual %b", $time, want.msg_end, mend);
			end
			if (user[1] !== want.err) begin
				mismatches++;
				$display("%0t: error expected %b actual %b", $time, want.err, user[1]);
			end
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata  = '0;   // [7:0] in_byte
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [BYTE_W-1:0]     m_tdata;         // [7:0] out_byte
	logic                  m_tlast;
	logic [USER_W-1:0]     m_tuser;         // [0] run_last, [1] error

	codec_scoreboard book = new();
	stim_t           stim_q[$];
	logic [7:0]      pass_chars[$];
	int              burst_left = 1;
	int              stall_mode = 0;
	int              stall_span = 0;
	int              quiet_cycles = 0;

	url_percent_codec DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	// receiver backpressure: always ready, coin flips, or a fixed rhythm
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(20, 80);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (stall_span % 3) != 0;
		endcase
	end

	// result transfers go to the checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			book.check_result(m_tdata, m_tlast, m_tuser);
		end
	end

	// watchdog on cycles with no transfer on either stream
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// register write: setup cycle, then access cycle
	task automatic set_reg(input logic idx, input logic val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {31'b0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		book.set_register(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic add_item(input logic [7:0] b, input logic last);
		stim_t it;
		it.data = b;
		it.last = last;
		stim_q.push_back(it);
	endtask

	// one source transfer, called and returning at a falling edge
	task automatic push_byte(input logic [7:0] b, input logic last);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		book.note_byte(b, last);
		@(negedge clk);
	endtask

	// send the queued bytes in bursts with random gaps between them
	task automatic send_queue();
		stim_t it;
		while (stim_q.size() != 0) begin
			it = stim_q.pop_front();
			push_byte(it.data, it.last);
			burst_left = burst_left - 1;
			if (burst_left <= 0 && stim_q.size() != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// hold off until every predicted result is in and the pipe is quiet
	task automatic wait_idle();
		while (book.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_pass();
		return pass_chars[$urandom_range(0, pass_chars.size() - 1)];
	endfunction

	// a byte that is not an uppercase hex digit, lowercase hex often
	function automatic logic [7:0] pick_non_hex();
		logic [7:0] c;
		logic [4:0] v;
		if ($urandom_range(0, 1) == 1) return 8'($urandom_range(8'h61, 8'h66));
		do begin
			c = 8'($urandom);
			v = digit_value(c);
		end while (!v[4]);
		return c;
	endfunction

	// a byte that decode mode refuses outright
	function automatic logic [7:0] pick_disallowed();
		logic [7:0] c;
		do begin
			c = 8'($urandom);
		end while (char_passes(c) || c == CH_PERCENT);
		return c;
	endfunction

	task automatic build_encode_msg();
		int n;
		int sel;
		logic [7:0] c;
		n = $urandom_range(1, 10);
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 3);
			case (sel)
				0, 1: c = 8'($urandom);
				2: c = pick_pass();
				default: c = ($urandom_range(0, 1) == 1) ? CH_SPACE : CH_PERCENT;
			endcase
			add_item(c, k == n - 1);
		end
	endtask

	// mostly well-formed decode messages; noisy ones carry broken tokens
	task automatic build_decode_msg(input logic noisy);
		int n;
		int kind;
		logic fin;
		n = $urandom_range(1, 8);
		for (int k = 0; k < n; k++) begin
			fin = (k == n - 1);
			if (!noisy || $urandom_range(0, 99) < 65) begin
				kind = $urandom_range(0, 9);
				if (kind < 5) begin
					add_item(pick_pass(), fin);
				end else if (kind < 8) begin
					add_item(CH_PERCENT, 1'b0);
					add_item(nibble_char(4'($urandom)), 1'b0);
					add_item(nibble_char(4'($urandom)), fin);
				end else begin
					add_item(CH_PLUS, fin);
				end
			end else begin
				kind = $urandom_range(0, 5);
				case (kind)
					0: begin
						add_item(CH_PERCENT, 1'b0);
						add_item(pick_non_hex(), fin);
					end
					1: begin
						add_item(CH_PERCENT, 1'b0);
						add_item(nibble_char(4'($urandom)), 1'b0);
						add_item(pick_non_hex(), fin);
					end
					2: add_item(CH_PERCENT, fin);
					3: begin
						add_item(CH_PERCENT, 1'b0);
						add_item(nibble_char(4'($urandom)), fin);
					end
					4: add_item(pick_disallowed(), fin);
					default: add_item(8'($urandom), fin);
				endcase
			end
		end
	endtask

	initial begin
		for (int c = 0; c < 256; c++) begin
			if (char_passes(8'(c))) pass_chars.push_back(8'(c));
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// encode, no plus option: byte extremes, space escaped, top-bit byte
		set_reg(REG_DIRECTION, DIR_ENCODE);
		set_reg(REG_SPACE_PLUS, 1'b0);
		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(CH_SPACE, 1'b0);
		add_item("~", 1'b0);
		add_item(8'h80, 1'b1);
		send_queue();
		wait_idle();

		// encode with space to plus
		set_reg(REG_SPACE_PLUS, 1'b1);
		add_item(CH_SPACE, 1'b0);
		add_item(8'h0F, 1'b1);
		send_queue();
		wait_idle();

		// decode with plus option: good escape, plus as space, then the error cases
		set_reg(REG_DIRECTION, DIR_DECODE);
		add_item(CH_PERCENT, 1'b0);
		add_item("4", 1'b0);
		add_item("1", 1'b0);
		add_item(CH_PLUS, 1'b0);
		// lowercase digit aborts, rest of message dropped
		add_item(CH_PERCENT, 1'b0);
		add_item("4", 1'b0);
		add_item("a", 1'b0);
		add_item("z", 1'b1);
		// truncated escapes
		add_item(CH_PERCENT, 1'b1);
		add_item(CH_PERCENT, 1'b0);
		add_item("7", 1'b1);
		// high byte inside an escape
		add_item(CH_PERCENT, 1'b0);
		add_item(8'hC1, 1'b1);
		// space is not allowed in decode input
		add_item(CH_SPACE, 1'b1);
		// escape closing a message
		add_item(CH_PERCENT, 1'b0);
		add_item("2", 1'b0);
		add_item("B", 1'b1);
		send_queue();
		wait_idle();

		// direction flip mid-message keeps the pending escape
		add_item(CH_PERCENT, 1'b0);
		send_queue();
		wait_idle();
		set_reg(REG_DIRECTION, DIR_ENCODE);
		add_item("A", 1'b0);
		send_queue();
		wait_idle();
		set_reg(REG_DIRECTION, DIR_DECODE);
		add_item("4", 1'b0);
		add_item("1", 1'b1);
		send_queue();
		wait_idle();

		// decode without plus option: plus passes, space aborts
		set_reg(REG_SPACE_PLUS, 1'b0);
		add_item(CH_PLUS, 1'b0);
		add_item(CH_SPACE, 1'b1);
		send_queue();
		wait_idle();

		// random phases over all register settings
		for (int p = 0; p < 6; p++) begin
			set_reg(REG_DIRECTION, DIR_PLAN[p]);
			set_reg(REG_SPACE_PLUS, PLUS_PLAN[p]);
			while (stim_q.size() < PHASE_ITEMS) begin
				if (DIR_PLAN[p] == DIR_ENCODE) build_encode_msg();
				else build_decode_msg($urandom_range(0, 3) == 0);
			end
			send_queue();
			wait_idle();
		end

		$display("run covered %0d source bytes and %0d results, %0d of them errors,",
			book.bytes_in, book.results_out, book.error_results);
		$display("in encode and decode mode with and without the plus option");
		if (book.mismatches == 0 && book.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
